>>> rtl/core/chrt_pkg.sv
package chrt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam int unsigned LENGTH_BITS_DEF = 32;
	localparam int unsigned REF_BITS_DEF = 32;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_EMPTY   = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_LOOKUP  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_DEDUP    = 3'd1,
		ST_FULL     = 3'd2,
		ST_TOOLONG  = 3'd3,
		ST_DEC      = 3'd4,
		ST_REMOVED  = 3'd5,
		ST_FOUND    = 3'd6,
		ST_NOTFOUND = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCAN,
		S_WRITE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [63:0] query_hash;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] content_hash;
		logic [31:0] payload_length;
		logic [31:0] ref_count;
		logic [6:0]  entry_count;
	} rsp_t;

endpackage

>>> rtl/core/content_hash_refcount_table.sv
// Content-hash reference-count table. A request is taken when start is high and busy is low;
// its result, if any, appears for exactly one cycle with done high and must be captured then,
// since the receiver cannot stall. A payload byte that is not last goes through S_MUL, where
// the FNV multiply is formed from a register as a small constant product plus a shifted copy.
// A finishing byte then holds busy through S_SCAN, which reads one entry at a time, through
// S_WRITE when a new entry is appended, and through the response state S_RESP. The result
// shows in the cycle after S_RESP, when busy is already low. An empty add, a release or a
// lookup skips S_MUL. A removal moves the final entry into the freed slot through S_MOVE_RD
// and S_MOVE_WR. The table memory has one read and one write port.
module content_hash_refcount_table #(
	parameter int unsigned TABLE_ENTRIES = chrt_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned LENGTH_BITS = chrt_pkg::LENGTH_BITS_DEF,
	parameter int unsigned REF_BITS = chrt_pkg::REF_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  chrt_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output chrt_pkg::rsp_t rsp
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned EW = 64 + LENGTH_BITS + REF_BITS;
	localparam logic [LENGTH_BITS-1:0] MAX_LEN = {LENGTH_BITS{1'b1}};
	localparam logic [REF_BITS-1:0] MAX_REF = {REF_BITS{1'b1}};

	typedef chrt_pkg::rsp_t rsp_t_local;

	chrt_pkg::state_t state_q, state_n;

	logic [63:0]          hash_q;
	logic [LENGTH_BITS:0] len_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [1:0]           op_q;
	logic [63:0]          key_q;
	logic [LENGTH_BITS:0] klen_q;
	logic                 last_q;
	logic [63:0]          x_q;
	logic [63:0]          prod_lo, prod_hi;
	logic                 rd_ok_q;
	logic [AW-1:0]        slot_q;
	logic [LENGTH_BITS-1:0] slen_q;
	rsp_t_local           out_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	chrt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [63:0]            e_hash;
	logic [LENGTH_BITS-1:0] e_len;
	logic [REF_BITS-1:0]    e_ref;
	assign e_hash = rdata[EW-1 -: 64];
	assign e_len  = rdata[REF_BITS +: LENGTH_BITS];
	assign e_ref  = rdata[REF_BITS-1:0];

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != chrt_pkg::S_IDLE);

	logic hit;
	always_comb begin
		hit = rd_ok_q && (e_hash == key_q);
		if (op_q == chrt_pkg::REQ_BYTE || op_q == chrt_pkg::REQ_EMPTY) begin
			hit = hit && ({1'b0, e_len} == klen_q);
		end
	end

	function automatic logic [31:0] to32(input logic [63:0] v);
		return v[31:0];
	endfunction

	rsp_t_local out_n;
	logic           rsp_valid_n;
	logic [CW-1:0]  count_n;
	logic [CW-1:0]  idx_n;
	logic [63:0]    hash_n;
	logic [LENGTH_BITS:0] len_n;
	logic [AW-1:0]  slot_n;
	logic [LENGTH_BITS-1:0] slen_n;
	logic           rd_ok_n;

	always_comb begin
		state_n = state_q;
		out_n = out_q;
		rsp_valid_n = 1'b0;
		count_n = count_q;
		idx_n = idx_q;
		hash_n = hash_q;
		len_n = len_q;
		slot_n = slot_q;
		slen_n = slen_q;
		rd_ok_n = 1'b0;
		we = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			chrt_pkg::S_IDLE: begin
				idx_n = '0;
				raddr = '0;
				rd_ok_n = (count_q != '0);
				if (accept) begin
					if (req.req_type == chrt_pkg::REQ_BYTE) begin
						state_n = chrt_pkg::S_MUL;
					end else begin
						state_n = chrt_pkg::S_SCAN;
					end
				end
			end
			chrt_pkg::S_MUL: begin
				hash_n = prod_lo + prod_hi;
				if (len_q <= {1'b0, MAX_LEN}) begin
					len_n = len_q + 1'b1;
				end
				if (last_q) begin
					idx_n = '0;
					raddr = '0;
					rd_ok_n = (count_q != '0);
					state_n = chrt_pkg::S_SCAN;
				end else begin
					state_n = chrt_pkg::S_IDLE;
				end
			end
			chrt_pkg::S_SCAN: begin
				if ((op_q == chrt_pkg::REQ_BYTE) && klen_q > {1'b0, MAX_LEN}) begin
					out_n = '{chrt_pkg::ST_TOOLONG, key_q, to32(64'(MAX_LEN)), 32'd0,
						7'(count_q)};
					state_n = chrt_pkg::S_RESP;
				end else if (hit) begin
					slot_n = idx_q[AW-1:0];
					slen_n = e_len;
					case (op_q)
						chrt_pkg::REQ_LOOKUP: begin
							out_n = '{chrt_pkg::ST_FOUND, key_q, to32(64'(e_len)),
								to32(64'(e_ref)), 7'(count_q)};
							state_n = chrt_pkg::S_RESP;
						end
						chrt_pkg::REQ_RELEASE: begin
							if (e_ref > REF_BITS'(1)) begin
								we = 1'b1;
								waddr = idx_q[AW-1:0];
								wdata = {e_hash, e_len, e_ref - 1'b1};
								out_n = '{chrt_pkg::ST_DEC, key_q, to32(64'(e_len)),
									to32(64'(e_ref - 1'b1)), 7'(count_q)};
								state_n = chrt_pkg::S_RESP;
							end else begin
								raddr = AW'(count_q - 1'b1);
								state_n = chrt_pkg::S_MOVE_RD;
							end
						end
						default: begin
							we = 1'b1;
							waddr = idx_q[AW-1:0];
							wdata = {e_hash, e_len, (e_ref < MAX_REF) ? e_ref + 1'b1 : e_ref};
							out_n = '{chrt_pkg::ST_DEDUP, key_q, to32(64'(e_len)),
								to32(64'((e_ref < MAX_REF) ? e_ref + 1'b1 : e_ref)),
								7'(count_q)};
							state_n = chrt_pkg::S_RESP;
						end
					endcase
				end else if (idx_q + 1'b1 < count_q) begin
					idx_n = idx_q + 1'b1;
					raddr = AW'(idx_q + 1'b1);
					rd_ok_n = 1'b1;
				end else begin
					if (op_q == chrt_pkg::REQ_RELEASE || op_q == chrt_pkg::REQ_LOOKUP) begin
						out_n = '{chrt_pkg::ST_NOTFOUND, key_q, 32'd0, 32'd0, 7'(count_q)};
						state_n = chrt_pkg::S_RESP;
					end else if (count_q >= CW'(TABLE_ENTRIES)) begin
						out_n = '{chrt_pkg::ST_FULL, key_q,
							to32(64'(klen_q[LENGTH_BITS-1:0])), 32'd0, 7'(count_q)};
						state_n = chrt_pkg::S_RESP;
					end else begin
						state_n = chrt_pkg::S_WRITE;
					end
				end
			end
			chrt_pkg::S_WRITE: begin
				we = 1'b1;
				waddr = AW'(count_q);
				wdata = {key_q, klen_q[LENGTH_BITS-1:0], REF_BITS'(1)};
				count_n = count_q + 1'b1;
				out_n = '{chrt_pkg::ST_ADDED, key_q, to32(64'(klen_q[LENGTH_BITS-1:0])),
					32'd1, 7'(count_q + 1'b1)};
				state_n = chrt_pkg::S_RESP;
			end
			chrt_pkg::S_MOVE_RD: begin
				raddr = AW'(count_q - 1'b1);
				state_n = chrt_pkg::S_MOVE_WR;
			end
			chrt_pkg::S_MOVE_WR: begin
				we = 1'b1;
				waddr = slot_q;
				wdata = rdata;
				count_n = count_q - 1'b1;
				out_n = '{chrt_pkg::ST_REMOVED, key_q, to32(64'(slen_q)), 32'd0,
					7'(count_q - 1'b1)};
				state_n = chrt_pkg::S_RESP;
			end
			chrt_pkg::S_RESP: begin
				rsp_valid_n = 1'b1;
				state_n = chrt_pkg::S_IDLE;
			end
			default: state_n = chrt_pkg::S_IDLE;
		endcase
		if (state_q == chrt_pkg::S_SCAN && klen_q <= {1'b0, MAX_LEN} &&
			(op_q == chrt_pkg::REQ_BYTE || op_q == chrt_pkg::REQ_EMPTY)) begin
			hash_n = chrt_pkg::FNV_BASIS;
			len_n = '0;
		end
		if (state_q == chrt_pkg::S_SCAN && op_q == chrt_pkg::REQ_BYTE) begin
			hash_n = chrt_pkg::FNV_BASIS;
			len_n = '0;
		end
	end

	logic [63:0] key_mul;
	assign key_mul = hash_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chrt_pkg::S_IDLE;
			hash_q  <= chrt_pkg::FNV_BASIS;
			len_q   <= '0;
			count_q <= '0;
			done    <= 1'b0;
			rd_ok_q <= 1'b0;
			idx_q   <= '0;
			slot_q  <= '0;
			slen_q  <= '0;
			out_q   <= '0;
			key_q   <= '0;
			klen_q  <= '0;
			op_q    <= '0;
			last_q  <= 1'b0;
			x_q     <= '0;
		end else begin
			done    <= rsp_valid_n;
			count_q <= count_n;
			idx_q   <= idx_n;
			rd_ok_q <= rd_ok_n;
			slot_q  <= slot_n;
			slen_q  <= slen_n;
			out_q   <= out_n;
			hash_q  <= hash_n;
			len_q   <= len_n;
			state_q <= state_n;
			if (state_q == chrt_pkg::S_MUL) begin
				key_q  <= key_mul;
				klen_q <= (len_q <= {1'b0, MAX_LEN}) ? len_q + 1'b1 : len_q;
			end else if (accept) begin
				op_q   <= req.req_type;
				last_q <= req.last_byte;
				case (req.req_type)
					chrt_pkg::REQ_BYTE: begin
						x_q <= hash_q ^ {56'd0, req.data_byte};
					end
					chrt_pkg::REQ_EMPTY: begin
						key_q  <= chrt_pkg::FNV_BASIS;
						klen_q <= '0;
					end
					default: begin
						key_q  <= req.query_hash;
						klen_q <= '0;
					end
				endcase
			end
		end
	end

	// The FNV prime is 2^40 + 0x1b3, so the product is a small constant product plus a shift.
	assign prod_lo = x_q * 64'h1b3;
	assign prod_hi = {x_q[23:0], 40'd0};

	assign rsp = out_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

endmodule

>>> rtl/core/chrt_ram.sv
module chrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
